// ===== src/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg: shared types and constants for the anchor timing unit
// Command codes, register indexes, sequencer states and limits.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int TICK_BITS_DEF = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int DIV_BITS      = 48;
    localparam int MUL_BITS      = 48;
    localparam logic [19:0] PS_PER_US = 20'd1000000;
    localparam logic [21:0] WIN_MAX   = 22'h3FFFFF;
    localparam logic [15:0] TICK_PS_RST = 16'd30517;

    typedef enum logic [2:0] {
        FN_START   = 3'd0,
        FN_PREPARE = 3'd1,
        FN_SKIP    = 3'd2,
        FN_RX_OK   = 3'd3,
        FN_RX_MISS = 3'd4,
        FN_ADVANCE = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        REG_INTERVAL_TICKS  = 3'd0,
        REG_INTERVAL_REM_PS = 3'd1,
        REG_TICK_PS         = 3'd2,
        REG_WIDEN_STEP      = 3'd3,
        REG_WIDEN_MAX       = 3'd4,
        REG_TIMEOUT         = 3'd5,
        REG_EXP_DELAY       = 3'd6,
        REG_WIN_MARGIN      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

// ===== src/ble_anchor_timing_unit_core.sv =====
// ----------------------------------------------------------------------------
// ble_anchor_timing_unit_core: BLE slave connection anchor tracking
// Window widening, drift correction, supervision timeout, interval advance.
// ----------------------------------------------------------------------------
// One command is taken per request; the result is held in an output register
// until taken. Start, prepare, skip, advance and unknown commands show their
// result valid the cycle after accept. Receive-ok and receive-miss run a
// shared shift-add multiplier (one bit per cycle) and a shared restoring
// divider (one quotient bit per cycle; divisor tick_ps for receive-ok, 1e6
// for receive-miss). A receive-miss result is valid after ST_MUL and ST_DIV,
// a receive-ok result after ST_MUL, ST_DIV and ST_FIX.
// in_ready is low while a command is in work or its result waits.
// No clearing pass after reset.
module ble_anchor_timing_unit_core
#(
    parameter int TICK_BITS = bat_pkg::TICK_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bat_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [TICK_BITS-1:0]           load_anchor_tick,
    input  logic [15:0]                    load_anchor_rem_ps,
    input  logic [TICK_BITS-1:0]           load_last_rx_tick,
    input  logic [14:0]                    load_window_us,
    input  logic [15:0]                    measured_delay_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [TICK_BITS-1:0]           anchor_tick,
    output logic [15:0]                    anchor_rem_ps,
    output logic [21:0]                    rx_window_us,
    output logic [20:0]                    widening_us,
    output logic [15:0]                    event_count,
    output logic [15:0]                    miss_run,
    output logic [15:0]                    miss_run_max,
    output logic [15:0]                    rx_ok_total,
    output logic                           timed_out
);
    import bat_pkg::*;

    localparam int DW = DIV_BITS;
    localparam int CW = $clog2(DW + 1);

    // configuration
    logic [17:0] ivl_ticks_reg;
    logic [15:0] ivl_rem_reg;
    logic [15:0] tick_ps_reg;
    logic [11:0] wstep_reg;
    logic [20:0] wmax_reg;
    logic [24:0] tmo_reg;
    logic [9:0]  exp_dly_reg;
    logic [9:0]  margin_reg;

    // state
    logic [TICK_BITS-1:0] ntick_reg, ntick_next;
    logic [15:0] nrem_reg, nrem_next;
    logic [TICK_BITS-1:0] lgood_reg, lgood_next;
    logic [20:0] wacc_reg, wacc_next;
    logic [14:0] fwin_reg, fwin_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] mnow_reg, mnow_next;
    logic [15:0] mpeak_reg, mpeak_next;
    logic [15:0] good_reg, good_next;
    logic [21:0] win_reg, win_next;
    logic        tmo_flag_reg, tmo_flag_next;

    state_t state_reg, state_next;
    logic   is_miss_reg, is_miss_next;
    logic   neg_reg, neg_next;

    // shared datapath: shift-add multiplier then restoring divider
    logic [MUL_BITS-1:0] acc_reg, acc_next;   // product / dividend
    logic [MUL_BITS-1:0] mcand_reg, mcand_next;
    logic [19:0]         mplier_reg, mplier_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [19:0]         dvs_reg, dvs_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    logic [15:0] tp;
    assign tp = (tick_ps_reg == 16'd0) ? 16'd1 : tick_ps_reg;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_ticks_reg <= '0;
            ivl_rem_reg   <= '0;
            tick_ps_reg   <= TICK_PS_RST;
            wstep_reg     <= '0;
            wmax_reg      <= '0;
            tmo_reg       <= '0;
            exp_dly_reg   <= '0;
            margin_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_INTERVAL_TICKS:  ivl_ticks_reg <= cfg_data[17:0];
                REG_INTERVAL_REM_PS: ivl_rem_reg   <= cfg_data[15:0];
                REG_TICK_PS:         tick_ps_reg   <= cfg_data[15:0];
                REG_WIDEN_STEP:      wstep_reg     <= cfg_data[11:0];
                REG_WIDEN_MAX:       wmax_reg      <= cfg_data[20:0];
                REG_TIMEOUT:         tmo_reg       <= cfg_data[24:0];
                REG_EXP_DELAY:       exp_dly_reg   <= cfg_data[9:0];
                REG_WIN_MARGIN:      margin_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ntick_reg    <= '0;
            nrem_reg     <= '0;
            lgood_reg    <= '0;
            wacc_reg     <= '0;
            fwin_reg     <= '0;
            skip_reg     <= '0;
            mnow_reg     <= '0;
            mpeak_reg    <= '0;
            good_reg     <= '0;
            win_reg      <= '0;
            tmo_flag_reg <= 1'b0;
            is_miss_reg  <= 1'b0;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ntick_reg    <= ntick_next;
            nrem_reg     <= nrem_next;
            lgood_reg    <= lgood_next;
            wacc_reg     <= wacc_next;
            fwin_reg     <= fwin_next;
            skip_reg     <= skip_next;
            mnow_reg     <= mnow_next;
            mpeak_reg    <= mpeak_next;
            good_reg     <= good_next;
            win_reg      <= win_next;
            tmo_flag_reg <= tmo_flag_next;
            is_miss_reg  <= is_miss_next;
            neg_reg      <= neg_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
    end

    logic [21:0]         wsum;
    logic [20:0]         wgrow;
    logic [23:0]         win_raw;
    logic [15:0]         dmag;
    logic                dneg;
    logic [TICK_BITS-1:0] elapsed;
    logic [DW:0]         rtrial;
    logic [DW-1:0]       rshift;
    logic [16:0]         rsum;
    logic [TICK_BITS-1:0] tsum;
    logic [DW-1:0]       qv;

    always_comb
    begin
        wsum  = {1'b0, wacc_reg} + {10'd0, wstep_reg};
        wgrow = (wsum > {1'b0, wmax_reg}) ? wmax_reg : wsum[20:0];
        win_raw = {1'b0, ({2'b00, margin_reg} + {1'b0, wgrow}), 1'b0}
                  + {9'd0, fwin_reg};
        dneg  = measured_delay_us < {6'd0, exp_dly_reg};
        dmag  = dneg ? ({6'd0, exp_dly_reg} - measured_delay_us)
                     : (measured_delay_us - {6'd0, exp_dly_reg});
        elapsed = ntick_reg - lgood_reg;
        rshift  = {rem_reg[DW-2:0], acc_reg[DW-1]};
        rtrial  = {1'b0, rshift} - {{(DW-19){1'b0}}, dvs_reg};
        rsum    = {1'b0, nrem_reg} + {1'b0, ivl_rem_reg};
        tsum    = ntick_reg + TICK_BITS'(ivl_ticks_reg);
        qv      = acc_reg;

        state_next    = state_reg;
        ntick_next    = ntick_reg;
        nrem_next     = nrem_reg;
        lgood_next    = lgood_reg;
        wacc_next     = wacc_reg;
        fwin_next     = fwin_reg;
        skip_next     = skip_reg;
        mnow_next     = mnow_reg;
        mpeak_next    = mpeak_reg;
        good_next     = good_reg;
        win_next      = win_reg;
        tmo_flag_next = tmo_flag_reg;
        is_miss_next  = is_miss_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    win_next      = '0;
                    tmo_flag_next = 1'b0;
                    state_next    = ST_DONE;
                    case (func)
                        FN_START:
                        begin
                            ntick_next = load_anchor_tick;
                            nrem_next  = load_anchor_rem_ps;
                            lgood_next = load_last_rx_tick;
                            fwin_next  = load_window_us;
                            wacc_next  = '0;
                            mnow_next  = '0;
                            mpeak_next = '0;
                            good_next  = '0;
                        end
                        FN_PREPARE:
                        begin
                            wacc_next = wgrow;
                            win_next  = (win_raw > {2'b00, WIN_MAX}) ? WIN_MAX
                                                                      : win_raw[21:0];
                        end
                        FN_SKIP:
                        begin
                            wacc_next = wgrow;
                            skip_next = skip_reg + 16'd1;
                        end
                        FN_RX_OK:
                        begin
                            // |drift| * 1e6, multiplier bits in mplier
                            is_miss_next = 1'b0;
                            neg_next     = dneg;
                            acc_next     = '0;
                            mcand_next   = MUL_BITS'(PS_PER_US);
                            mplier_next  = {4'd0, dmag};
                            cnt_next     = CW'(16);
                            state_next   = ST_MUL;
                        end
                        FN_RX_MISS:
                        begin
                            mnow_next = (mnow_reg == 16'hFFFF) ? mnow_reg
                                                               : mnow_reg + 16'd1;
                            if (mnow_next > mpeak_reg)
                                mpeak_next = mnow_next;
                            is_miss_next = 1'b1;
                            neg_next     = 1'b0;
                            acc_next     = '0;
                            mcand_next   = MUL_BITS'(elapsed);
                            mplier_next  = {4'd0, tp};
                            cnt_next     = CW'(16);
                            state_next   = ST_MUL;
                        end
                        FN_ADVANCE:
                        begin
                            if (rsum >= {1'b0, tp})
                            begin
                                nrem_next  = 16'(rsum - {1'b0, tp});
                                ntick_next = tsum + TICK_BITS'(1);
                            end
                            else
                            begin
                                nrem_next  = rsum[15:0];
                                ntick_next = tsum;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[MUL_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[19:1]};
                cnt_next    = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    // miss: divide product by 1e6; rx ok: |adj| by tick_ps
                    if (!is_miss_reg)
                    begin
                        if (neg_reg)
                        begin
                            if (acc_next > MUL_BITS'(nrem_reg))
                                acc_next = acc_next - MUL_BITS'(nrem_reg);
                            else
                            begin
                                acc_next = MUL_BITS'(nrem_reg) - acc_next;
                                neg_next = 1'b0;
                            end
                        end
                        else
                            acc_next = acc_next + MUL_BITS'(nrem_reg);
                    end
                    dvs_next   = is_miss_reg ? PS_PER_US : {4'd0, tp};
                    rem_next   = '0;
                    cnt_next   = CW'(DW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!rtrial[DW])
                begin
                    rem_next = rtrial[DW-1:0];
                    acc_next = {acc_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rshift;
                    acc_next = {acc_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (is_miss_reg)
                    begin
                        tmo_flag_next = (acc_next >= DW'(tmo_reg));
                        state_next    = ST_DONE;
                    end
                    else
                        state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // floor for negative: q = -(q+1), r = tp - r when r != 0
                if (neg_reg)
                begin
                    if (rem_reg != '0)
                    begin
                        ntick_next = ntick_reg - qv[TICK_BITS-1:0] - TICK_BITS'(1);
                        nrem_next  = 16'(tp - rem_reg[15:0]);
                    end
                    else
                    begin
                        ntick_next = ntick_reg - qv[TICK_BITS-1:0];
                        nrem_next  = '0;
                    end
                end
                else
                begin
                    ntick_next = ntick_reg + qv[TICK_BITS-1:0];
                    nrem_next  = rem_reg[15:0];
                end
                lgood_next = ntick_next;
                good_next  = good_reg + 16'd1;
                mnow_next  = '0;
                wacc_next  = '0;
                fwin_next  = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid     = (state_reg == ST_DONE);
    assign anchor_tick   = ntick_reg;
    assign anchor_rem_ps = nrem_reg;
    assign rx_window_us  = win_reg;
    assign widening_us   = wacc_reg;
    assign event_count   = skip_reg;
    assign miss_run      = mnow_reg;
    assign miss_run_max  = mpeak_reg;
    assign rx_ok_total   = good_reg;
    assign timed_out     = tmo_flag_reg;

endmodule

// ===== src/bat_checker.sv =====
// ----------------------------------------------------------------------------
// bat_checker: port-level checks for the anchor timing unit
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module bat_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] rx_window_us,
    input logic [15:0] miss_run,
    input logic [15:0] miss_run_max,
    input logic        timed_out
);
    // no new request while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("in_ready high while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(miss_run))
        else $error("result dropped while stalled");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> miss_run_max >= miss_run)
        else $error("miss peak below current run");

    a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timed_out && rx_window_us != 22'd0))
        else $error("window and timeout both reported");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accept");

endmodule

bind ble_anchor_timing_unit_core bat_checker u_bat_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rx_window_us (rx_window_us),
    .miss_run     (miss_run),
    .miss_run_max (miss_run_max),
    .timed_out    (timed_out)
);
